// ===== design/isotp_rx_pkg.sv =====
`default_nettype none
package isotp_rx_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 11;
  localparam int DATA_W   = 64;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int CNT_W    = 12;
  localparam int TICK_W   = 16;
  localparam int MAXLEN_W = 13;
  localparam int NB_W     = 3;
  localparam int PAY_W    = 56;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int QUEUE_DEPTH_DEF = 2;

  // input commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // protocol control nibble
  localparam logic [3:0] PCI_SINGLE = 4'd0;
  localparam logic [3:0] PCI_FIRST  = 4'd1;
  localparam logic [3:0] PCI_CONSEC = 4'd2;

  localparam logic [7:0] NEG_RESP_SID   = 8'h7F;
  localparam logic [7:0] RESP_PENDING   = 8'h78;
  localparam logic [7:0] FC_CTS_BYTE    = 8'h30;
  localparam logic [3:0] SF_MAX_LEN     = 4'h7;
  localparam logic [7:0] LOW_NIBBLE     = 8'h0F;

  // register indexes
  localparam logic [2:0] REG_RESPONSE_ID = 3'd0;
  localparam logic [2:0] REG_FC_ID       = 3'd1;
  localparam logic [2:0] REG_FC_FILL     = 3'd2;
  localparam logic [2:0] REG_TIMEOUT     = 3'd3;
  localparam logic [2:0] REG_MAX_LEN     = 3'd4;

  localparam logic [ID_W-1:0]     RST_RESPONSE_ID = 11'd1914;
  localparam logic [ID_W-1:0]     RST_FC_ID       = 11'd1808;
  localparam logic [BYTE_W-1:0]   RST_FC_FILL     = 8'd85;
  localparam logic [TICK_W-1:0]   RST_TIMEOUT     = 16'd1000;
  localparam logic [MAXLEN_W-1:0] RST_MAX_LEN     = 13'd4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 3'd0,
    KIND_FLOW    = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_NO_RESP = 3'd3,
    KIND_PARTIAL = 3'd4
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]     response_id;
    logic [ID_W-1:0]     flow_control_id;
    logic [BYTE_W-1:0]   fc_fill;
    logic [TICK_W-1:0]   timeout_ticks;
    logic [MAXLEN_W-1:0] max_len;
  } cfg_t;

  // one queued burst of results: payload bytes first, then an optional tail
  typedef struct packed {
    logic [PAY_W-1:0] payload;
    logic [NB_W-1:0]  nbytes;
    logic             has_tail;
    kind_t            tail;
    logic [CNT_W-1:0] rcv;
    logic [CNT_W-1:0] ann;
    logic             seen;
  } job_t;

endpackage
`default_nettype wire

// ===== design/isotp_rx_if.sv =====
`default_nettype none
interface isotp_rx_in_if;
  import isotp_rx_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ID_W-1:0]   frame_id;
  logic [DATA_W-1:0] frame_data;

  modport source (output valid, cmd, frame_id, frame_data, input ready);
  modport sink   (input valid, cmd, frame_id, frame_data, output ready);
endinterface

interface isotp_rx_out_if;
  import isotp_rx_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;
  logic [ID_W-1:0]   send_id;
  logic [DATA_W-1:0] send_data;
  logic [CNT_W-1:0]  bytes_received;
  logic [CNT_W-1:0]  bytes_announced;
  logic              saw_any_frame;
  logic              last;

  modport source (output valid, kind, data_byte, send_id, send_data, bytes_received,
                  bytes_announced, saw_any_frame, last, input ready);
  modport sink   (input valid, kind, data_byte, send_id, send_data, bytes_received,
                  bytes_announced, saw_any_frame, last, output ready);
endinterface
`default_nettype wire

// ===== design/isotp_rx_front.sv =====
`default_nettype none
module isotp_rx_front (
  input  logic                clk,
  input  logic                rst_n,
  input  isotp_rx_pkg::cfg_t  cfg,
  isotp_rx_in_if.sink         in_ch,
  output logic                job_valid,
  output isotp_rx_pkg::job_t  job,
  input  logic                job_ready
);
  import isotp_rx_pkg::*;

  logic              waiting_r, waiting_nxt;
  logic              segmented_r, segmented_nxt;
  logic              seen_r, seen_nxt;
  logic [CNT_W-1:0]  rcv_r, rcv_nxt;
  logic [CNT_W-1:0]  ann_r, ann_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;

  logic              accept;
  logic [7:0]        b0, b1, b3;
  logic [3:0]        pci, len_nib;
  logic [NB_W-1:0]   sf_len3, sf_len, ff_n, cf_n;
  logic              sf_pending;
  logic [CNT_W-1:0]  ff_ann, rem_ann, cf_rcv;
  logic [MAXLEN_W-1:0] rem_max;

  // min of a small limit and a count
  function automatic logic [NB_W-1:0] clamp_nb(input logic [NB_W-1:0] lim,
                                               input logic [MAXLEN_W-1:0] v);
    logic [NB_W-1:0] r;
    if (v < MAXLEN_W'(lim)) r = v[NB_W-1:0];
    else r = lim;
    return r;
  endfunction

  assign accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = job_ready;

  assign b0      = in_ch.frame_data[63:56];
  assign b1      = in_ch.frame_data[55:48];
  assign b3      = in_ch.frame_data[39:32];
  assign pci     = b0[7:4];
  assign len_nib = b0[3:0] & LOW_NIBBLE[3:0];

  assign sf_len3    = (len_nib > SF_MAX_LEN) ? SF_MAX_LEN[NB_W-1:0] : len_nib[NB_W-1:0];
  assign sf_len     = clamp_nb(sf_len3, cfg.max_len);
  assign sf_pending = (sf_len == NB_W'(3)) && (b1 == NEG_RESP_SID) && (b3 == RESP_PENDING);

  assign ff_ann = {len_nib, b1};
  assign ff_n   = clamp_nb(clamp_nb(NB_W'(6), {1'b0, ff_ann}), cfg.max_len);

  assign rem_ann = (ann_r > rcv_r) ? ann_r - rcv_r : '0;
  assign rem_max = (cfg.max_len > {1'b0, rcv_r}) ? cfg.max_len - {1'b0, rcv_r} : '0;
  assign cf_n    = clamp_nb(clamp_nb(NB_W'(7), {1'b0, rem_ann}), rem_max);
  assign cf_rcv  = rcv_r + CNT_W'(cf_n);

  always_comb begin
    waiting_nxt   = waiting_r;
    segmented_nxt = segmented_r;
    seen_nxt      = seen_r;
    rcv_nxt       = rcv_r;
    ann_nxt       = ann_r;
    ticks_nxt     = ticks_r;
    job_valid     = 1'b0;
    job           = '0;
    job.tail      = KIND_DONE;
    if (accept) begin
      case (in_ch.cmd)
        CMD_START: begin
          waiting_nxt   = 1'b1;
          segmented_nxt = 1'b0;
          seen_nxt      = 1'b0;
          rcv_nxt       = '0;
          ann_nxt       = '0;
          ticks_nxt     = cfg.timeout_ticks;
        end
        CMD_TICK: begin
          if (waiting_r) begin
            if (ticks_r > TICK_W'(1)) begin
              ticks_nxt = ticks_r - TICK_W'(1);
            end else begin
              ticks_nxt     = '0;
              waiting_nxt   = 1'b0;
              job_valid     = 1'b1;
              job.has_tail  = 1'b1;
              job.tail      = (segmented_r && rcv_r != '0) ? KIND_PARTIAL : KIND_NO_RESP;
              job.rcv       = rcv_r;
              job.ann       = ann_r;
              job.seen      = seen_r;
            end
          end
        end
        CMD_FRAME: begin
          if (waiting_r && in_ch.frame_id == cfg.response_id) begin
            seen_nxt = 1'b1;
            case (pci)
              PCI_SINGLE: begin
                if (sf_pending) begin
                  ticks_nxt = cfg.timeout_ticks;
                end else begin
                  rcv_nxt      = CNT_W'(sf_len);
                  waiting_nxt  = 1'b0;
                  job_valid    = 1'b1;
                  job.payload  = in_ch.frame_data[PAY_W-1:0];
                  job.nbytes   = sf_len;
                  job.has_tail = 1'b1;
                  job.tail     = KIND_DONE;
                  job.rcv      = CNT_W'(sf_len);
                  job.ann      = ann_r;
                  job.seen     = 1'b1;
                end
              end
              PCI_FIRST: begin
                ann_nxt       = ff_ann;
                segmented_nxt = 1'b1;
                rcv_nxt       = CNT_W'(ff_n);
                ticks_nxt     = cfg.timeout_ticks;
                job_valid     = 1'b1;
                job.payload   = {in_ch.frame_data[47:0], 8'h00};
                job.nbytes    = ff_n;
                job.has_tail  = 1'b1;
                job.tail      = KIND_FLOW;
              end
              PCI_CONSEC: begin
                rcv_nxt      = cf_rcv;
                ticks_nxt    = cfg.timeout_ticks;
                job.payload  = in_ch.frame_data[PAY_W-1:0];
                job.nbytes   = cf_n;
                job.tail     = KIND_DONE;
                job.rcv      = cf_rcv;
                job.ann      = ann_r;
                job.seen     = 1'b1;
                if (cf_rcv >= ann_r) begin
                  waiting_nxt  = 1'b0;
                  job.has_tail = 1'b1;
                end
                job_valid = (cf_n != '0) || (cf_rcv >= ann_r);
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= 1'b0;
      segmented_r <= 1'b0;
      seen_r      <= 1'b0;
      rcv_r       <= '0;
      ann_r       <= '0;
      ticks_r     <= '0;
    end else begin
      waiting_r   <= waiting_nxt;
      segmented_r <= segmented_nxt;
      seen_r      <= seen_nxt;
      rcv_r       <= rcv_nxt;
      ann_r       <= ann_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/isotp_rx_fifo.sv =====
`default_nettype none
module isotp_rx_fifo #(
  parameter int DEPTH = isotp_rx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  isotp_rx_pkg::job_t push_data,
  output logic               push_ready,
  output logic               pop_valid,
  output isotp_rx_pkg::job_t pop_data,
  input  logic               pop_ready
);
  import isotp_rx_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== design/isotp_rx_back.sv =====
`default_nettype none
module isotp_rx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  isotp_rx_pkg::cfg_t cfg,
  input  logic               job_valid,
  input  isotp_rx_pkg::job_t job,
  output logic               job_ready,
  isotp_rx_out_if.source     out_ch
);
  import isotp_rx_pkg::*;

  logic              busy_r;
  job_t              cur_r;
  logic              out_valid_r;
  kind_t             kind_r;
  logic [BYTE_W-1:0] byte_r;
  logic [ID_W-1:0]   sid_r;
  logic [DATA_W-1:0] sdata_r;
  logic [CNT_W-1:0]  rcv_r, ann_r;
  logic              saw_r, last_r;

  logic              emit, is_byte, is_last, is_status;
  logic [DATA_W-1:0] fc_frame;

  assign emit      = busy_r && (!out_valid_r || out_ch.ready);
  assign is_byte   = (cur_r.nbytes != '0);
  assign is_last   = is_byte ? (cur_r.nbytes == NB_W'(1) && !cur_r.has_tail) : 1'b1;
  assign is_status = (cur_r.tail != KIND_FLOW);
  assign job_ready = !busy_r || (emit && is_last);
  assign fc_frame  = {FC_CTS_BYTE, 16'h0000, {5{cfg.fc_fill}}};

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.data_byte       = byte_r;
  assign out_ch.send_id         = sid_r;
  assign out_ch.send_data       = sdata_r;
  assign out_ch.bytes_received  = rcv_r;
  assign out_ch.bytes_announced = ann_r;
  assign out_ch.saw_any_frame   = saw_r;
  assign out_ch.last            = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_ready) busy_r <= job_valid;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      cur_r <= job;
    end else if (emit && is_byte) begin
      // advance to the next payload byte
      cur_r.payload <= cur_r.payload << BYTE_W;
      cur_r.nbytes  <= cur_r.nbytes - NB_W'(1);
    end
    if (emit) begin
      last_r <= is_last;
      if (is_byte) begin
        kind_r  <= KIND_DATA;
        byte_r  <= cur_r.payload[PAY_W-1 -: BYTE_W];
        sid_r   <= '0;
        sdata_r <= '0;
        rcv_r   <= '0;
        ann_r   <= '0;
        saw_r   <= 1'b0;
      end else begin
        kind_r  <= cur_r.tail;
        byte_r  <= '0;
        sid_r   <= is_status ? '0 : cfg.flow_control_id;
        sdata_r <= is_status ? '0 : fc_frame;
        rcv_r   <= is_status ? cur_r.rcv : '0;
        ann_r   <= is_status ? cur_r.ann : '0;
        saw_r   <= is_status && cur_r.seen;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/isotp_reassembly_receiver.sv =====
// Path: the first result of an item passes the job queue, the job register of the output
// sequencer and the output register. Throughput: one item per cycle at the input while the
// job queue has room; the output sequencer then drives one word per cycle while not stalled.
// Reset: rst_n is synchronous, active low; it idles the exchange, empties the queue and
// the output register, and returns the configuration registers to their default values.
`default_nettype none
module isotp_reassembly_receiver #(
  parameter int QUEUE_DEPTH = isotp_rx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  isotp_rx_in_if.sink                          in_ch,
  isotp_rx_out_if.source                       out_ch,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [isotp_rx_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [isotp_rx_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [isotp_rx_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import isotp_rx_pkg::*;

  logic [ID_W-1:0]     resp_id_r;
  logic [ID_W-1:0]     fc_id_r;
  logic [BYTE_W-1:0]   fill_r;
  logic [TICK_W-1:0]   timeout_r;
  logic [MAXLEN_W-1:0] max_len_r;
  logic [2:0]          reg_idx;
  logic                wr_en;
  cfg_t                cfg;

  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  job_t q_push_data, q_pop_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_id_r <= RST_RESPONSE_ID;
      fc_id_r   <= RST_FC_ID;
      fill_r    <= RST_FC_FILL;
      timeout_r <= RST_TIMEOUT;
      max_len_r <= RST_MAX_LEN;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RESPONSE_ID: resp_id_r <= pwdata[ID_W-1:0];
        REG_FC_ID:       fc_id_r   <= pwdata[ID_W-1:0];
        REG_FC_FILL:     fill_r    <= pwdata[BYTE_W-1:0];
        REG_TIMEOUT:     timeout_r <= pwdata[TICK_W-1:0];
        REG_MAX_LEN:     max_len_r <= pwdata[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RESPONSE_ID: prdata = APB_DATA_W'(resp_id_r);
      REG_FC_ID:       prdata = APB_DATA_W'(fc_id_r);
      REG_FC_FILL:     prdata = APB_DATA_W'(fill_r);
      REG_TIMEOUT:     prdata = APB_DATA_W'(timeout_r);
      REG_MAX_LEN:     prdata = APB_DATA_W'(max_len_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.response_id     = resp_id_r;
  assign cfg.flow_control_id = fc_id_r;
  assign cfg.fc_fill         = fill_r;
  assign cfg.timeout_ticks   = timeout_r;
  assign cfg.max_len         = max_len_r;

  isotp_rx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .job_valid (q_push_valid),
    .job       (q_push_data),
    .job_ready (q_push_ready)
  );

  isotp_rx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_data  (q_push_data),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_data   (q_pop_data),
    .pop_ready  (q_pop_ready)
  );

  isotp_rx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (q_pop_valid),
    .job       (q_pop_data),
    .job_ready (q_pop_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== design/isotp_rx_checker.sv =====
`default_nettype none
module isotp_rx_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [isotp_rx_pkg::KIND_W-1:0] out_kind,
  input logic                            out_last,
  input logic [isotp_rx_pkg::CNT_W-1:0]  out_rcv,
  input logic                            out_saw,
  input logic [isotp_rx_pkg::ID_W-1:0]   out_sid
);
  import isotp_rx_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("output word changed while stalled");

  // flow control always closes the burst of a first frame
  a_flow_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FLOW |-> out_last)
    else $error("flow control word not marked last");

  // a status word ends its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_NO_RESP ||
                  out_kind == KIND_PARTIAL) |-> out_last)
    else $error("status word not marked last");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_rcv == '0 && !out_saw && out_sid == '0)
    else $error("data word carries status or send fields");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind isotp_reassembly_receiver isotp_rx_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_last  (out_ch.last),
  .out_rcv   (out_ch.bytes_received),
  .out_saw   (out_ch.saw_any_frame),
  .out_sid   (out_ch.send_id)
);
`default_nettype wire
